// ===== rtl/core/catalog_record_stream_parser_assert.svh =====
// Assertion macros shared by the catalog parser modules.
`ifndef CATALOG_RECORD_STREAM_PARSER_ASSERT_SVH
`define CATALOG_RECORD_STREAM_PARSER_ASSERT_SVH

// Condition that holds at every clock edge out of reset.
`define CRSP_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define CRSP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define CRSP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/crsp_pkg.sv =====
// Types and constants of the catalog record stream parser.
package crsp_pkg;

  typedef enum logic [1:0] {
    KIND_NAME   = 2'd0,
    KIND_RECORD = 2'd1,
    KIND_TITLE  = 2'd2,
    KIND_STATUS = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    ST_OK        = 4'd0,
    ST_MAGIC     = 4'd1,
    ST_VERSION   = 4'd2,
    ST_ITEMS     = 4'd3,
    ST_NAME_LONG = 4'd4,
    ST_TITLE_LONG= 4'd5,
    ST_TRUNCATED = 4'd6,
    ST_TRAILING  = 4'd7,
    ST_TOO_LARGE = 4'd8
  } status_t;

  typedef enum logic [4:0] {
    PH_HEADER = 5'b00001,
    PH_NAME   = 5'b00010,
    PH_RECORD = 5'b00100,
    PH_TITLE  = 5'b01000,
    PH_DONE   = 5'b10000
  } phase_t;

  typedef struct packed {
    kind_t       kind;
    status_t     status;
    logic [4:0]  item_index;
    logic [5:0]  item_total;
    logic [31:0] item_key;
    logic [31:0] item_duration;
    logic [31:0] item_offset;
    logic [6:0]  title_len;
    logic [7:0]  text_byte;
    logic        run_end;
  } result_t;

  // Results caused by one accepted byte: an optional data result, then an optional status result.
  typedef struct packed {
    logic    d_valid;
    result_t d_res;
    logic    s_valid;
    result_t s_res;
  } step_t;

  localparam int IN_DATA_W   = 8;
  localparam int OUT_DATA_W  = 128;
  localparam int OUT_USER_W  = 2;
  localparam int QUEUE_SLOTS = 3;

  localparam logic [3:0] SIG_LEN       = 4'd4;
  localparam logic [3:0] POS_VERSION   = 4'd5;
  localparam logic [3:0] POS_ITEMS     = 4'd7;
  localparam logic [3:0] POS_NAME_LEN  = 4'd9;
  localparam logic [3:0] HDR_LAST      = 4'd11;
  localparam logic [3:0] POS_KEY       = 4'd3;
  localparam logic [3:0] POS_DURATION  = 4'd7;
  localparam logic [3:0] POS_OFFSET    = 4'd11;
  localparam logic [3:0] POS_TITLE_LEN = 4'd13;
  localparam logic [3:0] REC_LAST      = 4'd15;

  localparam logic [15:0] VERSION_ONE = 16'd1;

  localparam logic [7:0] SIGNATURE [4] = '{8'h4D, 8'h50, 8'h58, 8'h47};

endpackage

// ===== rtl/core/catalog_record_stream_parser.sv =====
// Catalog record stream parser: byte decoder and three-slot result queue.
// Results are written into the queue at the clock edge that accepts their byte.
// Throughput: one byte per cycle while the queue holds at most one result; in_tready is low
// while it holds more, and the last byte of a blob adds a status result to the queue.
// Reset: rst_n (synchronous, active low) empties the queue and restarts the decoder.
module catalog_record_stream_parser #(
  parameter int MAX_ITEMS      = 32,
  parameter int NAME_CAPACITY  = 64,
  parameter int TITLE_CAPACITY = 128,
  parameter int BLOB_MAX_BYTES = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [crsp_pkg::IN_DATA_W-1:0]      in_tdata,   // [7:0] data_byte
  input  logic                                in_tlast,   // last_byte
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [3:0] status, [8:4] item_index, [14:9] item_total, [46:15] item_key,
  // [78:47] item_duration, [110:79] item_offset, [117:111] title_len,
  // [125:118] text_byte, [127:126] zero
  output logic [crsp_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic [crsp_pkg::OUT_USER_W-1:0]     out_tuser,  // [1:0] kind
  output logic                                out_tlast   // run_end
);

  `include "catalog_record_stream_parser_assert.svh"

  crsp_pkg::step_t   step;
  crsp_pkg::result_t q_r   [crsp_pkg::QUEUE_SLOTS];
  crsp_pkg::result_t q_nxt [crsp_pkg::QUEUE_SLOTS];
  crsp_pkg::result_t head;
  logic [1:0]        cnt_r, cnt_nxt;
  logic [1:0]        base, base2;
  logic              in_acc, pop;

  assign in_acc = in_tvalid && in_tready;
  assign pop    = out_tvalid && out_tready;

  crsp_parser #(
    .MAX_ITEMS      (MAX_ITEMS),
    .NAME_CAPACITY  (NAME_CAPACITY),
    .TITLE_CAPACITY (TITLE_CAPACITY),
    .BLOB_MAX_BYTES (BLOB_MAX_BYTES)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (in_acc),
    .data_byte (in_tdata),
    .last_byte (in_tlast),
    .step      (step)
  );

  always_comb begin
    // Advance the queue on a pop, then append this item's results behind it.
    for (int i = 0; i < crsp_pkg::QUEUE_SLOTS - 1; i++) begin
      q_nxt[i] = pop ? q_r[i+1] : q_r[i];
    end
    q_nxt[crsp_pkg::QUEUE_SLOTS-1] = q_r[crsp_pkg::QUEUE_SLOTS-1];
    base  = cnt_r - 2'(pop);
    base2 = base;
    if (in_acc && step.d_valid) begin
      q_nxt[base] = step.d_res;
      base2       = base + 2'd1;
    end
    if (in_acc && step.s_valid) begin
      q_nxt[base2] = step.s_res;
    end
    cnt_nxt = base2 + 2'(in_acc && step.s_valid);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign in_tready  = cnt_r <= 2'd1;
  assign out_tvalid = cnt_r != 2'd0;
  assign head       = q_r[0];
  assign out_tuser  = head.kind;
  assign out_tlast  = head.run_end;
  assign out_tdata  = {2'b00, head.text_byte, head.title_len, head.item_offset,
                       head.item_duration, head.item_key, head.item_total,
                       head.item_index, head.status};

  `CRSP_ASSERT_NXT(a_status_queued, in_acc && in_tlast, out_tvalid,
                   "no result offered after the last byte")
  `CRSP_ASSERT_IMP(a_status_ends_run, out_tvalid && out_tuser == crsp_pkg::KIND_STATUS,
                   out_tlast, "status result without run end")
  `CRSP_ASSERT_NXT(a_pop_drains, pop && !in_acc, cnt_r == $past(cnt_r) - 2'd1,
                   "queue count did not drop on a pop")

endmodule

// ===== rtl/core/crsp_parser.sv =====
// Byte-wise header, name, record and title decoder with first-error tracking.
module crsp_parser #(
  parameter int MAX_ITEMS      = 32,
  parameter int NAME_CAPACITY  = 64,
  parameter int TITLE_CAPACITY = 128,
  parameter int BLOB_MAX_BYTES = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                acc,
  input  logic [7:0]          data_byte,
  input  logic                last_byte,
  output crsp_pkg::step_t     step
);

  `include "catalog_record_stream_parser_assert.svh"

  localparam int BC_W = $clog2(BLOB_MAX_BYTES + 2);
  localparam int IW   = $clog2(MAX_ITEMS + 1);
  localparam logic [BC_W-1:0] BLOB_MAX  = BC_W'(BLOB_MAX_BYTES);
  localparam logic [15:0]     ITEMS_MAX = 16'(MAX_ITEMS);
  localparam logic [15:0]     NAME_CAP  = 16'(NAME_CAPACITY);
  localparam logic [15:0]     TITLE_CAP = 16'(TITLE_CAPACITY);

  crsp_pkg::phase_t  phase_r, phase_nxt;
  crsp_pkg::status_t err_r, err_nxt;
  logic [BC_W-1:0]   bc_r, bc_nxt;
  logic [3:0]        pos_r, pos_nxt;
  logic [23:0]       fshift_r, fshift_nxt;
  logic [IW-1:0]     items_r, items_nxt;
  logic [IW-1:0]     seen_r, seen_nxt;
  logic [IW-1:0]     seen_inc;
  logic [15:0]       text_r, text_nxt;
  logic [31:0]       key_r, key_nxt;
  logic [31:0]       dur_r, dur_nxt;
  logic [31:0]       off_r, off_nxt;
  logic [31:0]       word;
  logic              oversize;

  assign word     = {fshift_r, data_byte};
  assign seen_inc = seen_r + 1'b1;

  always_comb begin
    phase_nxt  = phase_r;
    err_nxt    = err_r;
    pos_nxt    = pos_r;
    fshift_nxt = fshift_r;
    items_nxt  = items_r;
    seen_nxt   = seen_r;
    text_nxt   = text_r;
    key_nxt    = key_r;
    dur_nxt    = dur_r;
    off_nxt    = off_r;
    step       = '0;

    // Saturate just above the size limit.
    bc_nxt   = (bc_r <= BLOB_MAX) ? bc_r + 1'b1 : bc_r;
    oversize = bc_nxt > BLOB_MAX;

    if (err_r == crsp_pkg::ST_OK) begin
      if (oversize) begin
        err_nxt = crsp_pkg::ST_TOO_LARGE;
      end else begin
        fshift_nxt = word[23:0];
        unique case (phase_r)
          crsp_pkg::PH_HEADER: begin
            if (pos_r < crsp_pkg::SIG_LEN) begin
              if (data_byte != crsp_pkg::SIGNATURE[pos_r[1:0]]) err_nxt = crsp_pkg::ST_MAGIC;
            end else if (pos_r == crsp_pkg::POS_VERSION) begin
              if (word[15:0] != crsp_pkg::VERSION_ONE) err_nxt = crsp_pkg::ST_VERSION;
            end else if (pos_r == crsp_pkg::POS_ITEMS) begin
              if (word[15:0] > ITEMS_MAX) err_nxt = crsp_pkg::ST_ITEMS;
              else items_nxt = IW'(word[15:0]);
            end else if (pos_r == crsp_pkg::POS_NAME_LEN) begin
              text_nxt = word[15:0];
              if (word[15:0] >= NAME_CAP) err_nxt = crsp_pkg::ST_NAME_LONG;
            end
            pos_nxt = pos_r + 1'b1;
            if (err_nxt == crsp_pkg::ST_OK && pos_r == crsp_pkg::HDR_LAST) begin
              pos_nxt = '0;
              if (text_r != '0) phase_nxt = crsp_pkg::PH_NAME;
              else if (seen_r >= items_r) phase_nxt = crsp_pkg::PH_DONE;
              else phase_nxt = crsp_pkg::PH_RECORD;
            end
          end
          crsp_pkg::PH_NAME: begin
            step.d_valid         = 1'b1;
            step.d_res.kind      = crsp_pkg::KIND_NAME;
            step.d_res.text_byte = data_byte;
            text_nxt             = text_r - 1'b1;
            if (text_r == 16'd1) begin
              pos_nxt   = '0;
              phase_nxt = (seen_r >= items_r) ? crsp_pkg::PH_DONE : crsp_pkg::PH_RECORD;
            end
          end
          crsp_pkg::PH_RECORD: begin
            if (pos_r == crsp_pkg::POS_KEY) key_nxt = word;
            else if (pos_r == crsp_pkg::POS_DURATION) dur_nxt = word;
            else if (pos_r == crsp_pkg::POS_OFFSET) off_nxt = word;
            else if (pos_r == crsp_pkg::POS_TITLE_LEN) text_nxt = word[15:0];
            pos_nxt = pos_r + 1'b1;
            if (pos_r == crsp_pkg::REC_LAST) begin
              pos_nxt = '0;
              if (text_r >= TITLE_CAP) begin
                // Drop the record.
                err_nxt = crsp_pkg::ST_TITLE_LONG;
              end else begin
                step.d_valid             = 1'b1;
                step.d_res.kind          = crsp_pkg::KIND_RECORD;
                step.d_res.item_index    = 5'(seen_r);
                step.d_res.item_key      = key_r;
                step.d_res.item_duration = dur_r;
                step.d_res.item_offset   = off_r;
                step.d_res.title_len     = 7'(text_r);
                if (text_r != '0) begin
                  phase_nxt = crsp_pkg::PH_TITLE;
                end else begin
                  seen_nxt  = seen_inc;
                  phase_nxt = (seen_inc >= items_r) ? crsp_pkg::PH_DONE : crsp_pkg::PH_RECORD;
                end
              end
            end
          end
          crsp_pkg::PH_TITLE: begin
            step.d_valid          = 1'b1;
            step.d_res.kind       = crsp_pkg::KIND_TITLE;
            step.d_res.item_index = 5'(seen_r);
            step.d_res.text_byte  = data_byte;
            text_nxt              = text_r - 1'b1;
            if (text_r == 16'd1) begin
              seen_nxt  = seen_inc;
              pos_nxt   = '0;
              phase_nxt = (seen_inc >= items_r) ? crsp_pkg::PH_DONE : crsp_pkg::PH_RECORD;
            end
          end
          crsp_pkg::PH_DONE: begin
            err_nxt = crsp_pkg::ST_TRAILING;
          end
          default: begin
            phase_nxt = crsp_pkg::PH_HEADER;
          end
        endcase
      end
    end

    step.d_res.run_end = !last_byte;

    if (last_byte) begin
      step.s_valid      = 1'b1;
      step.s_res.kind   = crsp_pkg::KIND_STATUS;
      step.s_res.run_end = 1'b1;
      priority if (oversize) step.s_res.status = crsp_pkg::ST_TOO_LARGE;
      else if (err_nxt != crsp_pkg::ST_OK) step.s_res.status = err_nxt;
      else if (phase_nxt == crsp_pkg::PH_DONE) step.s_res.status = crsp_pkg::ST_OK;
      else step.s_res.status = crsp_pkg::ST_TRUNCATED;
      if (phase_nxt != crsp_pkg::PH_HEADER) step.s_res.item_total = 6'(items_nxt);
      // Return to the start of a new blob.
      phase_nxt = crsp_pkg::PH_HEADER;
      err_nxt   = crsp_pkg::ST_OK;
      bc_nxt    = '0;
      pos_nxt   = '0;
      items_nxt = '0;
      seen_nxt  = '0;
      text_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= crsp_pkg::PH_HEADER;
      err_r   <= crsp_pkg::ST_OK;
      bc_r    <= '0;
      pos_r   <= '0;
      items_r <= '0;
      seen_r  <= '0;
      text_r  <= '0;
    end else if (acc) begin
      phase_r <= phase_nxt;
      err_r   <= err_nxt;
      bc_r    <= bc_nxt;
      pos_r   <= pos_nxt;
      items_r <= items_nxt;
      seen_r  <= seen_nxt;
      text_r  <= text_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      fshift_r <= fshift_nxt;
      key_r    <= key_nxt;
      dur_r    <= dur_nxt;
      off_r    <= off_nxt;
    end
  end

  `CRSP_ASSERT_ALWAYS(a_phase_onehot, $onehot(phase_r), "parser phase is not one-hot")
  `CRSP_ASSERT_IMP(a_error_silences, err_r != crsp_pkg::ST_OK, !step.d_valid,
                   "data result produced after an error")
  `CRSP_ASSERT_NXT(a_last_restarts, acc && last_byte,
                   phase_r == crsp_pkg::PH_HEADER && bc_r == '0 && err_r == crsp_pkg::ST_OK,
                   "parser did not restart after the last byte")

endmodule

// ===== test/catalog_record_stream_parser_tb.sv =====
// Self-checking testbench for the catalog record stream parser.
`timescale 1ns / 100ps

module catalog_record_stream_parser_tb;

  localparam int MAX_ITEMS      = 32;
  localparam int NAME_CAPACITY  = 64;
  localparam int TITLE_CAPACITY = 128;
  localparam int BLOB_MAX_BYTES = 1024;
  localparam int HDR_LEN        = 12;
  localparam int REC_LEN        = 16;
  localparam int RANDOM_BYTES   = 280;
  localparam logic [31:0] SIG_WORD = 32'h4D50_5847;

  typedef enum int {
    BLOB_CLEAN, BLOB_BAD_SIG, BLOB_BAD_VERSION, BLOB_TOO_MANY, BLOB_NAME_LONG,
    BLOB_TITLE_LONG, BLOB_SHORT, BLOB_TRAILING, BLOB_NOISE
  } blob_kind_t;

  // Decodes the byte stream alongside the block and holds the results still owed.
  class catalog_decode_board;
    crsp_pkg::result_t pending_results[$];
    int                errors;
    int                results_seen;
    int                status_hits[9];
    crsp_pkg::phase_t  phase;
    int unsigned       byte_count;
    int                sub_pos;
    logic [31:0]       shift;
    logic [15:0]       version;
    logic [15:0]       items_expected;
    int                items_seen;
    logic [15:0]       text_left;
    logic [31:0]       rec_key;
    logic [31:0]       rec_dur;
    logic [31:0]       rec_off;
    crsp_pkg::status_t err;

    function new();
      errors = 0;
      results_seen = 0;
      foreach (status_hits[i]) status_hits[i] = 0;
      clear_parser();
    endfunction

    function void clear_parser();
      phase = crsp_pkg::PH_HEADER;
      byte_count = 0;
      sub_pos = 0;
      shift = '0;
      version = '0;
      items_expected = '0;
      items_seen = 0;
      text_left = '0;
      rec_key = '0;
      rec_dur = '0;
      rec_off = '0;
      err = crsp_pkg::ST_OK;
    endfunction

    function void begin_records();
      if (items_seen >= int'(items_expected)) begin
        phase = crsp_pkg::PH_DONE;
      end else begin
        phase = crsp_pkg::PH_RECORD;
        sub_pos = 0;
        shift = '0;
      end
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      crsp_pkg::result_t data_res;
      crsp_pkg::result_t stat_res;
      bit                have_data;
      bit                oversize;
      crsp_pkg::status_t st;
      have_data = 1'b0;
      data_res = '0;
      stat_res = '0;
      if (byte_count <= BLOB_MAX_BYTES) byte_count++;
      oversize = byte_count > BLOB_MAX_BYTES;
      if (err == crsp_pkg::ST_OK && oversize) begin
        err = crsp_pkg::ST_TOO_LARGE;
      end else if (err == crsp_pkg::ST_OK) begin
        shift = {shift[23:0], b};
        case (phase)
          crsp_pkg::PH_HEADER: begin
            if (sub_pos < crsp_pkg::SIG_LEN) begin
              if (b != SIG_WORD[31 - 8 * sub_pos -: 8]) err = crsp_pkg::ST_MAGIC;
            end else if (sub_pos == crsp_pkg::POS_VERSION) begin
              version = shift[15:0];
              if (version != crsp_pkg::VERSION_ONE) err = crsp_pkg::ST_VERSION;
            end else if (sub_pos == crsp_pkg::POS_ITEMS) begin
              items_expected = shift[15:0];
              if (items_expected > MAX_ITEMS) err = crsp_pkg::ST_ITEMS;
            end else if (sub_pos == crsp_pkg::POS_NAME_LEN) begin
              text_left = shift[15:0];
              if (text_left >= NAME_CAPACITY) err = crsp_pkg::ST_NAME_LONG;
            end
            sub_pos++;
            if (err == crsp_pkg::ST_OK && sub_pos >= HDR_LEN) begin
              if (text_left > 0) phase = crsp_pkg::PH_NAME;
              else begin_records();
            end
          end
          crsp_pkg::PH_NAME: begin
            have_data = 1'b1;
            data_res.kind = crsp_pkg::KIND_NAME;
            data_res.text_byte = b;
            text_left--;
            if (text_left == 0) begin_records();
          end
          crsp_pkg::PH_RECORD: begin
            if (sub_pos == crsp_pkg::POS_KEY) rec_key = shift;
            else if (sub_pos == crsp_pkg::POS_DURATION) rec_dur = shift;
            else if (sub_pos == crsp_pkg::POS_OFFSET) rec_off = shift;
            else if (sub_pos == crsp_pkg::POS_TITLE_LEN) text_left = shift[15:0];
            sub_pos++;
            if (sub_pos >= REC_LEN) begin
              if (text_left >= TITLE_CAPACITY) begin
                err = crsp_pkg::ST_TITLE_LONG;
              end else begin
                have_data = 1'b1;
                data_res.kind = crsp_pkg::KIND_RECORD;
                data_res.item_index = items_seen[4:0];
                data_res.item_key = rec_key;
                data_res.item_duration = rec_dur;
                data_res.item_offset = rec_off;
                data_res.title_len = text_left[6:0];
                if (text_left > 0) begin
                  phase = crsp_pkg::PH_TITLE;
                end else begin
                  items_seen++;
                  begin_records();
                end
              end
            end
          end
          crsp_pkg::PH_TITLE: begin
            have_data = 1'b1;
            data_res.kind = crsp_pkg::KIND_TITLE;
            data_res.item_index = items_seen[4:0];
            data_res.text_byte = b;
            text_left--;
            if (text_left == 0) begin
              items_seen++;
              begin_records();
            end
          end
          default: begin
            err = crsp_pkg::ST_TRAILING;
          end
        endcase
      end

      if (last) begin
        if (oversize) st = crsp_pkg::ST_TOO_LARGE;
        else if (err != crsp_pkg::ST_OK) st = err;
        else if (phase == crsp_pkg::PH_DONE) st = crsp_pkg::ST_OK;
        else st = crsp_pkg::ST_TRUNCATED;
        stat_res.kind = crsp_pkg::KIND_STATUS;
        stat_res.status = st;
        if (phase != crsp_pkg::PH_HEADER && items_expected <= MAX_ITEMS)
          stat_res.item_total = items_expected[5:0];
        stat_res.run_end = 1'b1;
        status_hits[st]++;
        clear_parser();
      end else if (have_data) begin
        data_res.run_end = 1'b1;
      end
      if (have_data) pending_results.push_back(data_res);
      if (last) pending_results.push_back(stat_res);
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_result(logic [1:0] user, logic [127:0] data, logic tlast);
      crsp_pkg::result_t want;
      results_seen++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none actual kind %0d data %h last %0b",
                 $time, user, data, tlast);
        return;
      end
      want = pending_results.pop_front();
      check_field("kind", 32'(want.kind), 32'(user));
      check_field("status", 32'(want.status), 32'(data[3:0]));
      check_field("item_index", 32'(want.item_index), 32'(data[8:4]));
      check_field("item_total", 32'(want.item_total), 32'(data[14:9]));
      check_field("item_key", want.item_key, data[46:15]);
      check_field("item_duration", want.item_duration, data[78:47]);
      check_field("item_offset", want.item_offset, data[110:79]);
      check_field("title_len", 32'(want.title_len), 32'(data[117:111]));
      check_field("text_byte", 32'(want.text_byte), 32'(data[125:118]));
      check_field("run_end", 32'(want.run_end), 32'(tlast));
    endfunction
  endclass

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [7:0]   in_tdata;
  logic         in_tlast;
  logic         out_tvalid;
  logic         out_tready;
  logic [127:0] out_tdata;
  logic [1:0]   out_tuser;
  logic         out_tlast;

  catalog_decode_board board = new();
  logic [7:0] blob_q[$];
  int         rec_at[$];
  int         title_plan[$];
  int         bytes_sent = 0;
  int         blobs_sent = 0;
  bit         send_burst = 1'b0;
  bit         drain_burst = 1'b0;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  catalog_record_stream_parser #(
    .MAX_ITEMS      (MAX_ITEMS),
    .NAME_CAPACITY  (NAME_CAPACITY),
    .TITLE_CAPACITY (TITLE_CAPACITY),
    .BLOB_MAX_BYTES (BLOB_MAX_BYTES)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  function automatic void push_be(logic [31:0] v, int n);
    for (int i = n - 1; i >= 0; i--) blob_q.push_back(v[8 * i +: 8]);
  endfunction

  function automatic logic [31:0] rand_word();
    int pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) return 32'h0;
    if (pick == 1) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  // Well-formed blob with the given name length and one record per title_plan entry.
  task automatic build_blob(int name_len);
    blob_q.delete();
    rec_at.delete();
    push_be(SIG_WORD, 4);
    push_be(32'(crsp_pkg::VERSION_ONE), 2);
    push_be(32'(title_plan.size()), 2);
    push_be(32'(name_len), 2);
    push_be($urandom, 2);
    repeat (name_len) blob_q.push_back(8'($urandom));
    foreach (title_plan[i]) begin
      rec_at.push_back(blob_q.size());
      push_be(rand_word(), 4);
      push_be(rand_word(), 4);
      push_be(rand_word(), 4);
      push_be(32'(title_plan[i]), 2);
      push_be($urandom, 2);
      repeat (title_plan[i]) blob_q.push_back(8'($urandom));
    end
  endtask

  task automatic send_byte(logic [7:0] b, logic last);
    int gap;
    if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    do @(negedge clk); while (!in_tready);
    @(posedge clk);
    board.note_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_blob();
    foreach (blob_q[i]) send_byte(blob_q[i], i == blob_q.size() - 1);
    blobs_sent++;
  endtask

  // Catalog with 32 records, the longest name and three longest titles.
  task automatic build_full_catalog(int spare_title);
    title_plan.delete();
    repeat (MAX_ITEMS) title_plan.push_back(0);
    title_plan[0] = TITLE_CAPACITY - 1;
    title_plan[7] = spare_title;
    title_plan[15] = TITLE_CAPACITY - 1;
    title_plan[MAX_ITEMS - 1] = TITLE_CAPACITY - 1;
    build_blob(NAME_CAPACITY - 1);
  endtask

  initial begin : stimulus
    int          start;
    int          n;
    int          pos;
    int          cut;
    int          pick;
    logic [15:0] v;
    blob_kind_t  mode;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tlast   <= 1'b0;
    rst_n      <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // header only, no records, ignored bytes all ones
    title_plan.delete();
    build_blob(0);
    blob_q[10] = 8'hFF;
    blob_q[11] = 8'hFF;
    send_blob();
    // single-byte blobs: wrong signature, a start that ends too soon, then wrong signature again
    send_byte(8'hFF, 1'b1);
    send_byte(8'h4D, 1'b1);
    send_byte(8'h00, 1'b1);

    // one byte over the size limit, the byte before it still decoded
    build_full_catalog(57);
    send_blob();

    start = bytes_sent;
    pick = 0;
    while (pick <= int'(BLOB_NOISE) || bytes_sent - start < RANDOM_BYTES) begin
      // walk every blob shape once, then favour clean blobs
      if (pick <= int'(BLOB_NOISE)) mode = blob_kind_t'(pick);
      else if ($urandom_range(0, 99) < 50) mode = BLOB_CLEAN;
      else mode = blob_kind_t'($urandom_range(1, int'(BLOB_NOISE)));
      pick++;

      n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 4);
      if (mode == BLOB_TITLE_LONG && n == 0) n = 1;
      title_plan.delete();
      repeat (n)
        title_plan.push_back(($urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
                                                         : $urandom_range(0, 6));
      build_blob(($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 5));

      case (mode)
        BLOB_BAD_SIG: begin
          pos = $urandom_range(0, 3);
          blob_q[pos] = blob_q[pos] ^ 8'($urandom_range(1, 255));
        end
        BLOB_BAD_VERSION: begin
          v = 16'($urandom_range(0, 65535));
          if (v == crsp_pkg::VERSION_ONE) v = 16'h0;
          blob_q[4] = v[15:8];
          blob_q[5] = v[7:0];
        end
        BLOB_TOO_MANY: begin
          v = 16'($urandom_range(MAX_ITEMS + 1, 65535));
          blob_q[6] = v[15:8];
          blob_q[7] = v[7:0];
        end
        BLOB_NAME_LONG: begin
          v = 16'($urandom_range(NAME_CAPACITY, 65535));
          blob_q[8] = v[15:8];
          blob_q[9] = v[7:0];
        end
        BLOB_TITLE_LONG: begin
          pos = rec_at[$urandom_range(0, rec_at.size() - 1)];
          v = ($urandom_range(0, 1) == 0) ? 16'(TITLE_CAPACITY)
                                          : 16'($urandom_range(TITLE_CAPACITY, 65535));
          blob_q[pos + 12] = v[15:8];
          blob_q[pos + 13] = v[7:0];
        end
        BLOB_SHORT: begin
          cut = $urandom_range(1, blob_q.size() - 1);
          while (blob_q.size() > cut) void'(blob_q.pop_back());
        end
        BLOB_TRAILING: begin
          repeat ($urandom_range(1, 4)) blob_q.push_back(8'($urandom));
        end
        BLOB_NOISE: begin
          blob_q.delete();
          repeat ($urandom_range(1, 20)) blob_q.push_back(8'($urandom));
          if ($urandom_range(0, 1) == 0) blob_q[0] = SIG_WORD[31:24];
        end
        default: begin
        end
      endcase
      send_blob();
    end

    in_tvalid <= 1'b0;
    while (board.pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("%0d bytes in %0d blobs sent, %0d results checked, %0d mismatches",
             bytes_sent, blobs_sent, board.results_seen, board.errors);
    $display("status counts ok %0d magic %0d version %0d items %0d name %0d title %0d",
             board.status_hits[crsp_pkg::ST_OK], board.status_hits[crsp_pkg::ST_MAGIC],
             board.status_hits[crsp_pkg::ST_VERSION], board.status_hits[crsp_pkg::ST_ITEMS],
             board.status_hits[crsp_pkg::ST_NAME_LONG],
             board.status_hits[crsp_pkg::ST_TITLE_LONG]);
    $display("  truncated %0d trailing %0d too large %0d",
             board.status_hits[crsp_pkg::ST_TRUNCATED],
             board.status_hits[crsp_pkg::ST_TRAILING],
             board.status_hits[crsp_pkg::ST_TOO_LARGE]);
    if (board.errors == 0 && board.pending_results.size() == 0) begin
      $display("catalog_record_stream_parser_tb: clean");
    end else begin
      $display("catalog_record_stream_parser_tb: errors");
    end
    $finish;
  end

  initial begin : drain
    int stall;
    int taken;
    taken = 0;
    out_tready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if ($urandom_range(0, 39) == 0) drain_burst = !drain_burst;
      stall = drain_burst ? 0 : $urandom_range(0, 9);
      // long hold so the result queue fills and the input stalls
      if (taken == 150 || taken == 500) stall = 300;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(negedge clk); while (!out_tvalid);
      board.check_result(out_tuser, out_tdata, out_tlast);
      taken++;
      @(posedge clk);
    end
  end

  initial begin : watchdog
    #1_000_000;
    $display("catalog_record_stream_parser_tb: errors");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/crsp_pkg.sv
rtl/core/crsp_parser.sv
rtl/core/catalog_record_stream_parser.sv
test/catalog_record_stream_parser_tb.sv
